// File: rtl/core/http_chunked_decoder_assert.svh
// Assertion macros shared by the chunked decoder modules.
// Each macro expects i_clk and i_rst_n in scope.
`ifndef HTTP_CHUNKED_DECODER_ASSERT_SVH
`define HTTP_CHUNKED_DECODER_ASSERT_SVH

// Same-cycle implication check.
`define HCD_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");

// Next-cycle implication check.
`define HCD_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

// File: rtl/core/hcd_pkg.sv
package hcd_pkg;

    // Result kinds.
    localparam logic [2:0] K_FRAME = 3'd0;
    localparam logic [2:0] K_DATA  = 3'd1;
    localparam logic [2:0] K_HEAD  = 3'd2;
    localparam logic [2:0] K_END   = 3'd3;
    localparam logic [2:0] K_ERR   = 3'd4;

    // Error codes.
    localparam logic E_BAD_SYNTAX = 1'b0;
    localparam logic E_TOO_LARGE  = 1'b1;

    // Configuration register indexes.
    localparam logic CFG_MAX_EXT = 1'b0;
    localparam logic CFG_MAX_TRL = 1'b1;

    // Framing characters.
    localparam logic [7:0] B_CR   = 8'h0D;
    localparam logic [7:0] B_LF   = 8'h0A;
    localparam logic [7:0] B_SEMI = 8'h3B;

    localparam logic [15:0] MAX_EXT_RESET = 16'd256;
    localparam logic [15:0] MAX_TRL_RESET = 16'd4096;

    // One input request.
    typedef struct packed {
        logic [7:0] in_byte;
        logic       new_message;
    } t_in_item;

    // One result request.
    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  payload;
        logic [31:0] chunk_size;
        logic        error_code;
    } t_out_item;

    // Hex digit decode: bit 4 is the valid flag, bits 3:0 the digit value.
    function automatic logic [4:0] hex_decode(input logic [7:0] b);
        logic [7:0] low;
        logic [4:0] res;
        begin
            low = b | 8'h20;
            res = 5'd0;
            if (b >= 8'h30 && b <= 8'h39) begin
                res = {1'b1, 4'(b - 8'h30)};
            end else if (low >= 8'h61 && low <= 8'h66) begin
                res = {1'b1, 4'(low - 8'h61 + 8'd10)};
            end
            return res;
        end
    endfunction

endpackage

// File: rtl/core/hcd_parser.sv
`include "http_chunked_decoder_assert.svh"

module hcd_parser
    import hcd_pkg::*;
#(
    parameter int SIZE_BITS = 32,
    parameter int LEN_BITS  = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  t_in_item    i_item,
    input  logic [15:0] i_max_ext,
    input  logic [15:0] i_max_trl,
    output t_out_item   o_result
);

    localparam int CMP_W = (LEN_BITS > 16) ? LEN_BITS : 16;

    localparam logic [3:0] PH_START   = 4'd0;
    localparam logic [3:0] PH_SIZE    = 4'd1;
    localparam logic [3:0] PH_EXT     = 4'd2;
    localparam logic [3:0] PH_EXT_LF  = 4'd3;
    localparam logic [3:0] PH_DATA    = 4'd4;
    localparam logic [3:0] PH_DATA_CR = 4'd5;
    localparam logic [3:0] PH_DATA_LF = 4'd6;
    localparam logic [3:0] PH_LEXT    = 4'd7;
    localparam logic [3:0] PH_LEXT_LF = 4'd8;
    localparam logic [3:0] PH_TRL     = 4'd9;
    localparam logic [3:0] PH_TRL_LF  = 4'd10;
    localparam logic [3:0] PH_HDR     = 4'd11;
    localparam logic [3:0] PH_HDR_LF  = 4'd12;
    localparam logic [3:0] PH_DONE    = 4'd13;
    localparam logic [3:0] PH_ERR_BAD = 4'd14;
    localparam logic [3:0] PH_ERR_BIG = 4'd15;

    logic [3:0]           r_phase,    n_phase;
    logic [SIZE_BITS-1:0] r_size,     n_size;
    logic [LEN_BITS-1:0]  r_ext_cnt,  n_ext_cnt;
    logic                 r_ext_seen, n_ext_seen;
    logic [LEN_BITS-1:0]  r_trl_cnt,  n_trl_cnt;
    logic                 r_trl_seen, n_trl_seen;

    // Working copy of the state, cleared when a new message starts.
    logic [3:0]           c_phase;
    logic [SIZE_BITS-1:0] c_size;
    logic [LEN_BITS-1:0]  c_ext_cnt;
    logic                 c_ext_seen;
    logic [LEN_BITS-1:0]  c_trl_cnt;
    logic                 c_trl_seen;

    logic [4:0]  hex;
    logic [7:0]  b;
    logic        size_zero;
    logic        size_over;
    logic        ext_over;
    logic [SIZE_BITS-1:0] size_dec;
    t_out_item   res;

    assign b         = i_item.in_byte;
    assign hex       = hex_decode(b);
    assign size_zero = (c_size == '0);
    // Another digit would overflow once any of the top four bits is set.
    assign size_over = |c_size[SIZE_BITS-1 -: 4];
    assign size_dec  = size_zero ? c_size : c_size - SIZE_BITS'(1);

    always_comb begin
        if (i_item.new_message) begin
            c_phase    = PH_START;
            c_size     = '0;
            c_ext_cnt  = '0;
            c_ext_seen = 1'b0;
            c_trl_cnt  = '0;
            c_trl_seen = 1'b0;
        end else begin
            c_phase    = r_phase;
            c_size     = r_size;
            c_ext_cnt  = r_ext_cnt;
            c_ext_seen = r_ext_seen;
            c_trl_cnt  = r_trl_cnt;
            c_trl_seen = r_trl_seen;
        end
    end

    // Next-state and result logic for one byte.
    always_comb begin
        n_phase    = c_phase;
        n_size     = c_size;
        n_ext_cnt  = c_ext_cnt;
        n_ext_seen = c_ext_seen;
        n_trl_cnt  = c_trl_cnt;
        n_trl_seen = c_trl_seen;
        ext_over   = 1'b0;
        res        = '0;
        res.kind   = K_FRAME;

        // The trailer span counts every byte once the first trailer byte is seen.
        if (c_trl_seen && (c_phase == PH_TRL || c_phase == PH_TRL_LF ||
                           c_phase == PH_HDR || c_phase == PH_HDR_LF) &&
            (c_trl_cnt != '1)) begin
            n_trl_cnt = c_trl_cnt + LEN_BITS'(1);
        end

        case (c_phase)
            PH_START: begin
                if (hex[4]) begin
                    n_size  = SIZE_BITS'(hex[3:0]);
                    n_phase = PH_SIZE;
                end else begin
                    n_phase = PH_ERR_BAD;
                end
            end
            PH_SIZE: begin
                if (size_over) begin
                    n_phase = PH_ERR_BIG;
                end else if (hex[4]) begin
                    n_size = {c_size[SIZE_BITS-5:0], hex[3:0]};
                end else begin
                    n_ext_seen = 1'b0;
                    n_ext_cnt  = '0;
                    if (b == B_CR) begin
                        n_phase = size_zero ? PH_LEXT_LF : PH_EXT_LF;
                    end else if (b == B_SEMI) begin
                        n_phase = size_zero ? PH_LEXT : PH_EXT;
                    end else begin
                        n_phase = PH_ERR_BAD;
                    end
                end
            end
            PH_EXT, PH_LEXT: begin
                // The first extension byte is offset zero and is never over.
                if (!c_ext_seen) begin
                    n_ext_seen = 1'b1;
                    n_ext_cnt  = '0;
                end else if (CMP_W'(c_ext_cnt) >= CMP_W'(i_max_ext)) begin
                    ext_over = 1'b1;
                end else if (c_ext_cnt != '1) begin
                    n_ext_cnt = c_ext_cnt + LEN_BITS'(1);
                end
                if (ext_over) begin
                    n_phase = PH_ERR_BAD;
                end else if (b == B_CR) begin
                    n_phase = (c_phase == PH_EXT) ? PH_EXT_LF : PH_LEXT_LF;
                end
            end
            PH_EXT_LF: begin
                if (b != B_LF) begin
                    n_phase = PH_ERR_BAD;
                end else begin
                    res.kind       = K_HEAD;
                    res.chunk_size = 32'(c_size);
                    n_phase        = size_zero ? PH_DATA_CR : PH_DATA;
                end
            end
            PH_DATA: begin
                res.kind    = K_DATA;
                res.payload = b;
                n_size      = size_dec;
                if (size_dec == '0) begin
                    n_phase = PH_DATA_CR;
                end
            end
            PH_DATA_CR: begin
                n_phase = (b == B_CR) ? PH_DATA_LF : PH_ERR_BAD;
            end
            PH_DATA_LF: begin
                n_phase = (b == B_LF) ? PH_START : PH_ERR_BAD;
            end
            PH_LEXT_LF: begin
                if (b != B_LF) begin
                    n_phase = PH_ERR_BAD;
                end else begin
                    res.kind = K_HEAD;
                    n_phase  = PH_TRL;
                end
            end
            PH_TRL: begin
                if (b == B_CR) begin
                    n_phase = PH_TRL_LF;
                end else if (!c_trl_seen) begin
                    n_trl_seen = 1'b1;
                    n_trl_cnt  = '0;
                    n_phase    = PH_HDR;
                end else if (CMP_W'(n_trl_cnt) > CMP_W'(i_max_trl)) begin
                    n_phase = PH_ERR_BAD;
                end else begin
                    n_phase = PH_HDR;
                end
            end
            PH_TRL_LF: begin
                if (b != B_LF) begin
                    n_phase = PH_ERR_BAD;
                end else begin
                    res.kind = K_END;
                    n_phase  = PH_DONE;
                end
            end
            PH_HDR: begin
                if (b == B_CR) begin
                    n_phase = PH_HDR_LF;
                end
            end
            PH_HDR_LF: begin
                n_phase = (b == B_LF) ? PH_TRL : PH_ERR_BAD;
            end
            PH_DONE: begin
                n_phase = PH_ERR_BAD;
            end
            default: begin
                // Error phases hold until a new message or reset.
                n_phase = c_phase;
            end
        endcase

        // Any error phase overrides the result fields.
        if (n_phase == PH_ERR_BAD || n_phase == PH_ERR_BIG) begin
            res.kind       = K_ERR;
            res.payload    = '0;
            res.chunk_size = '0;
            res.error_code = (n_phase == PH_ERR_BIG) ? E_TOO_LARGE : E_BAD_SYNTAX;
        end
    end

    assign o_result = res;

    // State registers advance once per processed byte.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_START;
            r_size     <= '0;
            r_ext_cnt  <= '0;
            r_ext_seen <= 1'b0;
            r_trl_cnt  <= '0;
            r_trl_seen <= 1'b0;
        end else if (i_en) begin
            r_phase    <= n_phase;
            r_size     <= n_size;
            r_ext_cnt  <= n_ext_cnt;
            r_ext_seen <= n_ext_seen;
            r_trl_cnt  <= n_trl_cnt;
            r_trl_seen <= n_trl_seen;
        end
    end

    // A payload phase always has bytes left to count down.
    `HCD_ASSERT_IMP(a_data_nonzero, r_phase == PH_DATA, r_size != '0)

    // A syntax error stays until a new message starts.
    `HCD_ASSERT_NXT(a_err_sticky, i_en && !i_item.new_message && r_phase == PH_ERR_BAD,
                    r_phase == PH_ERR_BAD)

endmodule

// File: rtl/core/http_chunked_decoder.sv
// HTTP chunked body decoder. Feed one body byte per request on the input channel
// and take one result per byte on the output channel: framing byte, payload byte,
// chunk header done (with the parsed size), message end, or a sticky error with its
// code. The block sustains one byte per clock while the output is not stalled; a
// byte passes through the input register, then the result register, and the parser
// updates its state when the result register loads. Either side may stall at any
// time without loss. Setting new_message on a byte restarts parsing at a chunk size
// line and clears any error. The two limit registers are written through the
// configuration channel, which is always ready, and should only be written while no
// byte is in flight. There is no clearing pass after reset.
`include "http_chunked_decoder_assert.svh"

module http_chunked_decoder
    import hcd_pkg::*;
#(
    parameter int SIZE_BITS = 32,
    parameter int LEN_BITS  = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  t_in_item    i_data,
    output logic        o_valid,
    input  logic        i_stall,
    output t_out_item   o_data,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    logic [15:0] r_max_ext;
    logic [15:0] r_max_trl;
    logic        r_in_valid;
    t_in_item    r_in_item;
    logic        r_out_valid;
    t_out_item   r_out_item;
    t_out_item   step_result;
    logic        out_ready;
    logic        step;

    // Handshake: the result register frees up when it is empty or being taken.
    assign out_ready   = !r_out_valid || !i_stall;
    assign step        = r_in_valid && out_ready;
    assign o_stall     = r_in_valid && !out_ready;
    assign o_valid     = r_out_valid;
    assign o_data      = r_out_item;
    assign o_cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_ext <= MAX_EXT_RESET;
            r_max_trl <= MAX_TRL_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_MAX_EXT: r_max_ext <= i_cfg_data;
                CFG_MAX_TRL: r_max_trl <= i_cfg_data;
                default:     r_max_ext <= r_max_ext;
            endcase
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_in_item <= i_data;
        end
    end

    hcd_parser #(
        .SIZE_BITS (SIZE_BITS),
        .LEN_BITS  (LEN_BITS)
    ) u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (step),
        .i_item    (r_in_item),
        .i_max_ext (r_max_ext),
        .i_max_trl (r_max_trl),
        .o_result  (step_result)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_ready) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out_item <= step_result;
        end
    end

    // A held input byte is not dropped while the result side is blocked.
    `HCD_ASSERT_NXT(a_in_held, r_in_valid && !out_ready, r_in_valid)

    // A processed byte always produces a result.
    `HCD_ASSERT_NXT(a_step_result, step, r_out_valid)

endmodule

// File: sim/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import hcd_pkg::*;

    // Parser phases of the chunked body decoder.
    typedef enum logic [3:0] {
        S_START, S_SIZE, S_EXT, S_EXT_LF, S_DATA, S_DATA_CR, S_DATA_LF, S_LEXT,
        S_LEXT_LF, S_TRL, S_TRL_LF, S_HDR, S_HDR_LF, S_DONE, S_ERR_BAD, S_ERR_BIG
    } t_parse_phase;

    // A size line may take one more digit only while the size is at most the
    // largest 32-bit value divided by 16.
    localparam logic [63:0] SIZE_SHIFT_LIMIT = 64'h0FFF_FFFF;
    // Extension and trailer counters stop at the largest 16-bit value.
    localparam int unsigned LEN_SAT = 65535;

    // One row of the directed table: a request and, where it is obvious, its result.
    typedef struct packed {
        t_in_item  req;
        logic      typed;
        t_out_item want;
    } t_dir_row;

    localparam t_out_item NO_EXP     = '0;
    localparam t_out_item ERR_SYNTAX = '{K_ERR, 8'h00, 32'h0, E_BAD_SYNTAX};
    localparam t_out_item ERR_SIZE   = '{K_ERR, 8'h00, 32'h0, E_TOO_LARGE};
    localparam int DIR_ROWS = 26;

    localparam t_dir_row DIRECTED_ROWS [DIR_ROWS] = '{
        // A non-hex byte right after reset, then the error holds.
        '{'{"G", 1'b1}, 1'b1, ERR_SYNTAX},
        '{'{"x", 1'b0}, 1'b1, ERR_SYNTAX},
        // A new message with a two-byte chunk, an empty extension and extreme bytes.
        '{'{"2", 1'b1}, 1'b0, NO_EXP},
        '{'{B_SEMI, 1'b0}, 1'b0, NO_EXP},
        '{'{B_CR, 1'b0}, 1'b0, NO_EXP},
        '{'{B_LF, 1'b0}, 1'b1, '{K_HEAD, 8'h00, 32'd2, 1'b0}},
        '{'{8'h00, 1'b0}, 1'b1, '{K_DATA, 8'h00, 32'd0, 1'b0}},
        '{'{8'hFF, 1'b0}, 1'b1, '{K_DATA, 8'hFF, 32'd0, 1'b0}},
        '{'{B_CR, 1'b0}, 1'b0, NO_EXP},
        '{'{B_LF, 1'b0}, 1'b0, NO_EXP},
        // The last chunk with no trailer, the end of the message, then a stray byte.
        '{'{"0", 1'b0}, 1'b0, NO_EXP},
        '{'{B_CR, 1'b0}, 1'b0, NO_EXP},
        '{'{B_LF, 1'b0}, 1'b1, '{K_HEAD, 8'h00, 32'd0, 1'b0}},
        '{'{B_CR, 1'b0}, 1'b0, NO_EXP},
        '{'{B_LF, 1'b0}, 1'b1, '{K_END, 8'h00, 32'd0, 1'b0}},
        '{'{"a", 1'b0}, 1'b1, ERR_SYNTAX},
        // Eight hex digits fill the size; any further byte is too large.
        '{'{"F", 1'b1}, 1'b0, NO_EXP},
        '{'{"f", 1'b0}, 1'b0, NO_EXP},
        '{'{"f", 1'b0}, 1'b0, NO_EXP},
        '{'{"F", 1'b0}, 1'b0, NO_EXP},
        '{'{"f", 1'b0}, 1'b0, NO_EXP},
        '{'{"f", 1'b0}, 1'b0, NO_EXP},
        '{'{"f", 1'b0}, 1'b0, NO_EXP},
        '{'{"f", 1'b0}, 1'b0, NO_EXP},
        '{'{"0", 1'b0}, 1'b1, ERR_SIZE},
        '{'{B_CR, 1'b0}, 1'b1, ERR_SIZE}
    };

    logic        i_clk;
    logic        i_rst_n     = 1'b0;
    logic        i_valid     = 1'b0;
    logic        o_stall;
    t_in_item    i_data      = '0;
    logic        o_valid;
    logic        i_stall     = 1'b0;
    t_out_item   o_data;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_index = CFG_MAX_EXT;
    logic [15:0] i_cfg_data  = '0;

    http_chunked_decoder i_dut (.*);

    // Decoder state and limits as the testbench tracks them.
    t_parse_phase ph = S_START;
    logic [63:0]  size_acc = '0;
    int unsigned  ext_len = 0;
    bit           ext_open = 1'b0;
    int unsigned  trl_len = 0;
    bit           trl_open = 1'b0;
    logic [15:0]  lim_ext = MAX_EXT_RESET;
    logic [15:0]  lim_trl = MAX_TRL_RESET;

    t_out_item pending_results[$];
    t_in_item  msg_bytes[$];

    bit quiet = 1'b0;
    bit hold_request = 1'b0;
    int hold_left = 0;
    int stall_left = 0;
    int mismatches = 0;
    int requests_sent = 0;
    int results_seen = 0;
    int heads_seen = 0;
    int ends_seen = 0;
    int errors_seen = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #10ms;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic int hex_digit(logic [7:0] b);
        logic [7:0] folded;
        folded = b | 8'h20;
        if (b >= "0" && b <= "9") return int'(b - "0");
        if (folded >= "a" && folded <= "f") return int'(folded - "a") + 10;
        return -1;
    endfunction

    function automatic void clear_parser();
        ph = S_START;
        size_acc = '0;
        ext_len = 0;
        ext_open = 1'b0;
        trl_len = 0;
        trl_open = 1'b0;
    endfunction

    // Advances the tracked decoder state by one byte and returns its result.
    function automatic t_out_item parse_byte(t_in_item req);
        t_out_item  res;
        logic [7:0] b;
        int         h;
        bit         over;
        res = '0;
        res.kind = K_FRAME;
        b = req.in_byte;
        if (req.new_message) clear_parser();

        // Every byte inside the trailer section counts toward its span.
        if (trl_open && ph inside {S_TRL, S_TRL_LF, S_HDR, S_HDR_LF} && trl_len < LEN_SAT)
            trl_len++;

        h = hex_digit(b);
        case (ph)
            S_START: begin
                if (h >= 0) begin
                    size_acc = 64'(h);
                    ph = S_SIZE;
                end else begin
                    ph = S_ERR_BAD;
                end
            end
            S_SIZE: begin
                if (size_acc > SIZE_SHIFT_LIMIT) begin
                    ph = S_ERR_BIG;
                end else if (h >= 0) begin
                    size_acc = (size_acc << 4) + 64'(h);
                end else begin
                    ext_open = 1'b0;
                    ext_len = 0;
                    if (b == B_CR) ph = (size_acc == 0) ? S_LEXT_LF : S_EXT_LF;
                    else if (b == B_SEMI) ph = (size_acc == 0) ? S_LEXT : S_EXT;
                    else ph = S_ERR_BAD;
                end
            end
            S_EXT, S_LEXT: begin
                // The first extension byte opens the count at offset zero.
                over = 1'b0;
                if (!ext_open) begin
                    ext_open = 1'b1;
                    ext_len = 0;
                end else if (ext_len >= lim_ext) begin
                    over = 1'b1;
                end else if (ext_len < LEN_SAT) begin
                    ext_len++;
                end
                if (over) ph = S_ERR_BAD;
                else if (b == B_CR) ph = (ph == S_EXT) ? S_EXT_LF : S_LEXT_LF;
            end
            S_EXT_LF: begin
                if (b != B_LF) begin
                    ph = S_ERR_BAD;
                end else begin
                    res.kind = K_HEAD;
                    res.chunk_size = size_acc[31:0];
                    ph = (size_acc == 0) ? S_DATA_CR : S_DATA;
                end
            end
            S_DATA: begin
                res.kind = K_DATA;
                res.payload = b;
                if (size_acc > 0) size_acc--;
                if (size_acc == 0) ph = S_DATA_CR;
            end
            S_DATA_CR: ph = (b == B_CR) ? S_DATA_LF : S_ERR_BAD;
            S_DATA_LF: ph = (b == B_LF) ? S_START : S_ERR_BAD;
            S_LEXT_LF: begin
                if (b != B_LF) begin
                    ph = S_ERR_BAD;
                end else begin
                    res.kind = K_HEAD;
                    ph = S_TRL;
                end
            end
            S_TRL: begin
                // A new trailer line may not start beyond the trailer limit.
                if (b == B_CR) begin
                    ph = S_TRL_LF;
                end else if (!trl_open) begin
                    trl_open = 1'b1;
                    trl_len = 0;
                    ph = S_HDR;
                end else if (trl_len > lim_trl) begin
                    ph = S_ERR_BAD;
                end else begin
                    ph = S_HDR;
                end
            end
            S_TRL_LF: begin
                if (b != B_LF) begin
                    ph = S_ERR_BAD;
                end else begin
                    res.kind = K_END;
                    ph = S_DONE;
                end
            end
            S_HDR: if (b == B_CR) ph = S_HDR_LF;
            S_HDR_LF: ph = (b == B_LF) ? S_TRL : S_ERR_BAD;
            S_DONE: ph = S_ERR_BAD;
            default: ;
        endcase

        if (ph == S_ERR_BAD || ph == S_ERR_BIG) begin
            res = '0;
            res.kind = K_ERR;
            res.error_code = (ph == S_ERR_BIG) ? E_TOO_LARGE : E_BAD_SYNTAX;
        end
        return res;
    endfunction

    task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
        mismatches++;
        if (mismatches <= 40)
            $display("%0t: result %0d, %s: got 0x%0h, expected 0x%0h",
                     $time, results_seen, field, got, want);
    endtask

    task automatic check_result(t_out_item got);
        t_out_item want;
        results_seen++;
        case (got.kind)
            K_HEAD: heads_seen++;
            K_END: ends_seen++;
            K_ERR: errors_seen++;
            default: ;
        endcase
        if (pending_results.size() == 0) begin
            report_mismatch("result with no request pending", 32'(got.kind), 32'd0);
            return;
        end
        want = pending_results.pop_front();
        if (got.kind !== want.kind) report_mismatch("kind", 32'(got.kind), 32'(want.kind));
        if (got.payload !== want.payload)
            report_mismatch("payload", 32'(got.payload), 32'(want.payload));
        if (got.chunk_size !== want.chunk_size)
            report_mismatch("chunk_size", got.chunk_size, want.chunk_size);
        if (got.error_code !== want.error_code)
            report_mismatch("error_code", 32'(got.error_code), 32'(want.error_code));
    endtask

    // Result side: check each accepted result, then decide the stall for the next edge.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) check_result(o_data);

        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else if (hold_request) begin
            // A long hold lets the decoder fill up and stall its input.
            hold_request = 1'b0;
            hold_left = 299;
            i_stall <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            i_stall <= 1'b1;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 12) - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // Offers one request, waits for it to be taken and records its result.
    task automatic send_req(t_in_item req, bit typed, t_out_item want);
        t_out_item predicted;
        if (!quiet && $urandom_range(0, 9) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data <= req;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predicted = parse_byte(req);
        pending_results.push_back(typed ? want : predicted);
        requests_sent++;
    endtask

    task automatic send_batch();
        foreach (msg_bytes[k]) send_req(msg_bytes[k], 1'b0, NO_EXP);
        msg_bytes.delete();
    endtask

    task automatic wait_all_results();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // Both limits are written back to back; the channel stays valid in between.
    task automatic write_limits(logic [15:0] ext_lim, logic [15:0] trl_lim);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_MAX_EXT;
        i_cfg_data <= ext_lim;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        lim_ext = ext_lim;
        i_cfg_index <= CFG_MAX_TRL;
        i_cfg_data <= trl_lim;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        lim_trl = trl_lim;
        i_cfg_valid <= 1'b0;
    endtask

    function automatic void put(logic [7:0] b);
        t_in_item item;
        item.in_byte = b;
        item.new_message = 1'b0;
        msg_bytes.push_back(item);
    endfunction

    function automatic void put_crlf();
        put(B_CR);
        put(B_LF);
    endfunction

    // Free text for extensions and trailer lines: anything but CR.
    function automatic void put_text(int n);
        logic [7:0] b;
        repeat (n) begin
            do b = 8'($urandom_range(0, 255)); while (b == B_CR);
            put(b);
        end
    endfunction

    // Hex digits with leading zeros and a random letter case.
    function automatic void put_hex(longint unsigned v, int digits);
        logic [3:0] nib;
        for (int i = digits - 1; i >= 0; i--) begin
            nib = 4'(v >> (4 * i));
            if (nib < 10) put(8'h30 + 8'(nib));
            else put(($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'(nib) - 8'd10);
        end
    endfunction

    // Extension lengths straddle the current limit where it is small.
    function automatic void put_ext();
        if ($urandom_range(0, 2) == 0) begin
            put(B_SEMI);
            put_text($urandom_range(0, (lim_ext < 12) ? int'(lim_ext) + 2 : 12));
        end
    endfunction

    // A whole chunked message with random content, now and then damaged.
    function automatic void gen_message();
        int chunks;
        int sz;
        int r;
        int idx;
        chunks = $urandom_range(0, 3);
        for (int c = 0; c < chunks; c++) begin
            if ($urandom_range(0, 29) == 0) begin
                put_hex((longint'($urandom_range(1, 15)) << 32) | $urandom(), 9);
                put_crlf();
                continue;
            end
            r = $urandom_range(0, 19);
            sz = (r < 14) ? $urandom_range(1, 6) :
                 (r < 19) ? $urandom_range(7, 40) : $urandom_range(41, 200);
            put_hex(sz, ((sz > 15) ? 2 : 1) + $urandom_range(0, 2));
            put_ext();
            put_crlf();
            repeat (sz) put(8'($urandom_range(0, 255)));
            put_crlf();
        end

        // Last chunk, trailer lines and the closing empty line.
        put_hex(0, $urandom_range(1, 3));
        put_ext();
        put_crlf();
        repeat ($urandom_range(0, 3)) begin
            put_text($urandom_range(1, 10));
            put_crlf();
        end
        put_crlf();
        msg_bytes[0].new_message = ($urandom_range(0, 9) != 0);

        idx = $urandom_range(0, msg_bytes.size() - 1);
        r = $urandom_range(0, 19);
        if (r < 2) begin
            msg_bytes[idx].in_byte = 8'($urandom_range(0, 255));
        end else if (r == 2) begin
            msg_bytes[idx].in_byte = $urandom_range(0, 1) ? B_CR : B_LF;
        end else if (r == 3) begin
            while (msg_bytes.size() > idx + 1) void'(msg_bytes.pop_back());
        end
    endfunction

    function automatic void gen_noise();
        repeat ($urandom_range(1, 6)) begin
            put(8'($urandom_range(0, 255)));
            msg_bytes[$].new_message = ($urandom_range(0, 3) == 0);
        end
    endfunction

    task automatic run_random(int count);
        int start;
        start = requests_sent;
        while (requests_sent - start < count) begin
            if ($urandom_range(0, 6) == 0) gen_noise();
            else gen_message();
            send_batch();
        end
    endtask

    // Main sequence: reset, directed table, then random traffic under several limits.
    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIRECTED_ROWS[k])
            send_req(DIRECTED_ROWS[k].req, DIRECTED_ROWS[k].typed, DIRECTED_ROWS[k].want);
        run_random(190);

        for (int p = 1; p <= 5; p++) begin
            wait_all_results();
            case (p)
                1: write_limits(16'd0, 16'd0);
                2: write_limits(16'hFFFF, 16'hFFFF);
                3: write_limits(16'd2, 16'hFFFE);
                4: write_limits(16'($urandom_range(0, 10)), 16'($urandom_range(0, 40)));
                default: begin
                    write_limits(16'd7, 16'd30);
                    quiet = 1'b1;
                end
            endcase
            if (p == 1) hold_request = 1'b1;
            run_random(190);
        end

        wait_all_results();
        repeat (5) @(posedge i_clk);
        $display("Sent %0d requests under six limit settings, with one long output hold.",
                 requests_sent);
        $display("Saw %0d results: %0d chunk headers, %0d message ends, %0d errors.",
                 results_seen, heads_seen, ends_seen, errors_seen);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
